// ----- rtl/core/pcomp_pkg.sv -----
package pcomp_pkg;

  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned COL_W         = 7;
  localparam int unsigned ROW_W         = 8;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned PALETTE_DEPTH = 256;

  localparam logic [2:0] DISPOSAL_RESTORE = 3'd2;

  typedef enum logic [1:0] {
    FUNC_PALETTE = 2'd0,
    FUNC_LINE    = 2'd1,
    FUNC_PIXEL   = 2'd2
  } func_t;

  typedef struct packed {
    logic               is_write;
    logic [INDEX_W-1:0] addr;
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } entry_t;

endpackage

// ----- rtl/core/palette_line_compositor.sv -----
// Palette line compositor: turns palette-indexed line pixels into RGB565 writes.
// Request channel (req_valid / req_stall) carries one of three item kinds on
// func: palette write (index, entry_color), line start (line_x, line_y,
// line_width, disposal, transparent_index, background_index, has_transparency)
// or pixel (index). Pixel channel (pixel_valid / pixel_stall) returns out_x,
// out_y and out_color for each pixel that lands on screen and is not skipped.
// A front stage tracks the line and classifies requests; a queue of QUEUE_DEPTH
// entries feeds a back stage that owns the 256-entry palette RAM.
// Throughput: one request per cycle while req_stall is low, set by the single
// palette RAM port. A pixel goes through a queue slot, then the registered
// palette read, before it shows on the pixel channel.
// While pixel_stall is high the held pixel stays put, palette writes at the
// head of the queue still drain, and requests are taken until the queue fills.
// Reset clears the line state, the queue and the output; palette contents are
// kept and read as unknown until written.
module palette_line_compositor #(
  parameter int unsigned SCREEN_COLS = 128,
  parameter int unsigned SCREEN_ROWS = 160,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic [pcomp_pkg::INDEX_W-1:0] index,
  input  logic [pcomp_pkg::COLOR_W-1:0] entry_color,
  input  logic [pcomp_pkg::COORD_W-1:0] line_x,
  input  logic [pcomp_pkg::COORD_W-1:0] line_y,
  input  logic [pcomp_pkg::COORD_W-1:0] line_width,
  input  logic [2:0]                    disposal,
  input  logic [pcomp_pkg::INDEX_W-1:0] transparent_index,
  input  logic [pcomp_pkg::INDEX_W-1:0] background_index,
  input  logic                          has_transparency,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output logic [pcomp_pkg::COL_W-1:0]   out_x,
  output logic [pcomp_pkg::ROW_W-1:0]   out_y,
  output logic [pcomp_pkg::COLOR_W-1:0] out_color
);

  logic              push;
  logic              pop;
  logic              full;
  logic              not_empty;
  pcomp_pkg::entry_t push_data;
  pcomp_pkg::entry_t head;

  pcomp_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .func              (func),
    .index             (index),
    .entry_color       (entry_color),
    .line_x            (line_x),
    .line_y            (line_y),
    .line_width        (line_width),
    .disposal          (disposal),
    .transparent_index (transparent_index),
    .background_index  (background_index),
    .has_transparency  (has_transparency),
    .full              (full),
    .push              (push),
    .push_data         (push_data)
  );

  pcomp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  pcomp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (not_empty),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_color   (out_color)
  );

endmodule

// ----- rtl/core/pcomp_ram.sv -----
module pcomp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pcomp_fifo.sv -----
module pcomp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pcomp_pkg::entry_t push_data,
  input  logic              pop,
  output pcomp_pkg::entry_t head,
  output logic              not_empty,
  output logic              full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pcomp_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

// ----- rtl/core/pcomp_front.sv -----
module pcomp_front #(
  parameter int unsigned SCREEN_COLS = 128,
  parameter int unsigned SCREEN_ROWS = 160
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          func,
  input  logic [pcomp_pkg::INDEX_W-1:0]       index,
  input  logic [pcomp_pkg::COLOR_W-1:0]       entry_color,
  input  logic [pcomp_pkg::COORD_W-1:0]       line_x,
  input  logic [pcomp_pkg::COORD_W-1:0]       line_y,
  input  logic [pcomp_pkg::COORD_W-1:0]       line_width,
  input  logic [2:0]                          disposal,
  input  logic [pcomp_pkg::INDEX_W-1:0]       transparent_index,
  input  logic [pcomp_pkg::INDEX_W-1:0]       background_index,
  input  logic                                has_transparency,
  input  logic                                full,
  output logic                                push,
  output pcomp_pkg::entry_t                   push_data
);

  localparam int unsigned CW = pcomp_pkg::COORD_W;

  logic [pcomp_pkg::POS_W-1:0]   origin_col;
  logic [pcomp_pkg::ROW_W-1:0]   row;
  logic [pcomp_pkg::POS_W-1:0]   clipped_width;
  logic [pcomp_pkg::POS_W-1:0]   position;
  logic                          line_active;
  logic [pcomp_pkg::INDEX_W-1:0] skip_index;
  logic [pcomp_pkg::INDEX_W-1:0] fill_index;
  logic                          skip_on;
  logic                          restore_on;

  logic                          accept;
  logic                          on_screen;
  logic [CW:0]                   span;
  logic [CW-1:0]                 width_clip;
  logic                          line_ok;
  logic                          restore_new;
  logic                          in_line;
  logic [pcomp_pkg::INDEX_W-1:0] pix_index;
  logic [pcomp_pkg::POS_W-1:0]   col_sum;

  assign req_stall = full;
  assign accept    = req_valid && !req_stall;

  assign on_screen  = (line_y < CW'(SCREEN_ROWS)) && (line_x < CW'(SCREEN_COLS));
  assign span       = {1'b0, line_width} + {1'b0, line_x};
  assign width_clip = (span > (CW + 1)'(SCREEN_COLS)) ? CW'(SCREEN_COLS) - line_x
                                                       : line_width;
  assign line_ok     = on_screen && (width_clip != '0);
  assign restore_new = (disposal == pcomp_pkg::DISPOSAL_RESTORE);

  assign in_line   = line_active && (position < clipped_width);
  assign pix_index = (restore_on && index == skip_index) ? fill_index : index;
  assign col_sum   = origin_col + position;

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    unique case (func)
      pcomp_pkg::FUNC_PALETTE: begin
        push               = accept;
        push_data.is_write = 1'b1;
        push_data.addr     = index;
        push_data.color    = entry_color;
      end
      pcomp_pkg::FUNC_PIXEL: begin
        push               = accept && in_line && !(skip_on && pix_index == skip_index);
        push_data.is_write = 1'b0;
        push_data.addr     = pix_index;
        push_data.col      = col_sum[pcomp_pkg::COL_W-1:0];
        push_data.row      = row;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && func == pcomp_pkg::FUNC_LINE && line_ok) begin
      origin_col    <= line_x[pcomp_pkg::POS_W-1:0];
      row           <= line_y[pcomp_pkg::ROW_W-1:0];
      clipped_width <= width_clip[pcomp_pkg::POS_W-1:0];
      skip_index    <= transparent_index;
      fill_index    <= background_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      line_active <= 1'b0;
      skip_on     <= 1'b0;
      restore_on  <= 1'b0;
    end else if (accept) begin
      if (func == pcomp_pkg::FUNC_LINE) begin
        position    <= '0;
        line_active <= line_ok;
        if (line_ok) begin
          restore_on <= restore_new;
          skip_on    <= has_transparency && !restore_new;
        end
      end else if (func == pcomp_pkg::FUNC_PIXEL && line_active) begin
        if (in_line) begin
          position <= position + 1'b1;
        end else begin
          line_active <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_line_idle: assert property (@(posedge clk) disable iff (rst)
    accept && func == pcomp_pkg::FUNC_PIXEL && !line_active |-> !push)
    else $error("pixel pushed with no active line");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> position <= clipped_width)
    else $error("position past clipped width");
`endif

endmodule

// ----- rtl/core/pcomp_back.sv -----
module pcomp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pcomp_pkg::entry_t             head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output logic [pcomp_pkg::COL_W-1:0]   out_x,
  output logic [pcomp_pkg::ROW_W-1:0]   out_y,
  output logic [pcomp_pkg::COLOR_W-1:0] out_color
);

  logic rd_en;
  logic wr_en;
  logic slot_free;

  assign slot_free = !pixel_valid || !pixel_stall;
  assign pop       = head_valid && (head.is_write || slot_free);
  assign wr_en     = pop && head.is_write;
  assign rd_en     = pop && !head.is_write;

  pcomp_ram #(
    .WIDTH (pcomp_pkg::COLOR_W),
    .DEPTH (pcomp_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head.addr),
    .wdata (head.color),
    .re    (rd_en),
    .raddr (head.addr),
    .rdata (out_color)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_x <= head.col;
      out_y <= head.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (slot_free) begin
      pixel_valid <= rd_en;
    end
  end

`ifndef SYNTHESIS
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> pixel_valid)
    else $error("palette read lost");

  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |-> !rd_en)
    else $error("read issued over held pixel");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("palette write and read in one cycle");
`endif

endmodule

// ----- tb/pcomp_checker.sv -----
`timescale 1ns / 100ps

module pcomp_checker #(
  parameter int unsigned SCREEN_COLS = 128,
  parameter int unsigned SCREEN_ROWS = 160
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic [pcomp_pkg::INDEX_W-1:0] index,
  input  logic [pcomp_pkg::COLOR_W-1:0] entry_color,
  input  logic [pcomp_pkg::COORD_W-1:0] line_x,
  input  logic [pcomp_pkg::COORD_W-1:0] line_y,
  input  logic [pcomp_pkg::COORD_W-1:0] line_width,
  input  logic [2:0]                    disposal,
  input  logic [pcomp_pkg::INDEX_W-1:0] transparent_index,
  input  logic [pcomp_pkg::INDEX_W-1:0] background_index,
  input  logic                          has_transparency,
  input  logic                          pixel_valid,
  input  logic                          pixel_stall,
  input  logic [pcomp_pkg::COL_W-1:0]   out_x,
  input  logic [pcomp_pkg::ROW_W-1:0]   out_y,
  input  logic [pcomp_pkg::COLOR_W-1:0] out_color,
  output int                            fail_count,
  output int                            pending
);

  import pcomp_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } pixel_t;

  logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
  logic [COL_W-1:0]   org_col;
  logic [ROW_W-1:0]   cur_row;
  logic [POS_W-1:0]   span;
  logic [POS_W-1:0]   pos;
  logic               line_on;
  logic [INDEX_W-1:0] key_idx;
  logic [INDEX_W-1:0] fill_idx;
  logic               drop_key;
  logic               swap_key;
  pixel_t             expected_pixels [$];

  function automatic void log_fail(string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t             want;
    int unsigned        span_w;
    logic [INDEX_W-1:0] idx;
    if (rst) begin
      org_col  = '0;
      cur_row  = '0;
      span     = '0;
      pos      = '0;
      line_on  = 1'b0;
      key_idx  = '0;
      fill_idx = '0;
      drop_key = 1'b0;
      swap_key = 1'b0;
      expected_pixels.delete();
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (expected_pixels.size() == 0) begin
          log_fail($sformatf("unexpected pixel x=%0d y=%0d color=%04h",
                             out_x, out_y, out_color));
        end else begin
          want = expected_pixels.pop_front();
          if (out_x !== want.col || out_y !== want.row || out_color !== want.color) begin
            log_fail($sformatf("pixel mismatch: expected x=%0d y=%0d color=%04h, got x=%0d y=%0d color=%04h",
                               want.col, want.row, want.color, out_x, out_y, out_color));
          end
        end
      end
      if (req_valid && !req_stall) begin
        case (func)
          FUNC_PALETTE: begin
            palette[index] = entry_color;
          end
          FUNC_LINE: begin
            line_on = 1'b0;
            pos     = '0;
            span_w  = 32'(line_width);
            if (line_y < SCREEN_ROWS && line_x < SCREEN_COLS) begin
              if (span_w + line_x > SCREEN_COLS) begin
                span_w = SCREEN_COLS - line_x;
              end
              if (span_w != 0) begin
                org_col  = line_x[COL_W-1:0];
                cur_row  = line_y[ROW_W-1:0];
                span     = span_w[POS_W-1:0];
                key_idx  = transparent_index;
                fill_idx = background_index;
                swap_key = (disposal == DISPOSAL_RESTORE);
                drop_key = has_transparency && !swap_key;
                line_on  = 1'b1;
              end
            end
          end
          FUNC_PIXEL: begin
            if (line_on) begin
              if (pos >= span) begin
                line_on = 1'b0;
              end else begin
                want.col = org_col + pos[COL_W-1:0];
                want.row = cur_row;
                pos      = pos + 1'b1;
                idx      = index;
                if (swap_key && idx == key_idx) begin
                  idx = fill_idx;
                end
                if (!(drop_key && idx == key_idx)) begin
                  want.color = palette[idx];
                  expected_pixels.push_back(want);
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  import pcomp_pkg::*;

  localparam int unsigned SCREEN_W    = 128;
  localparam int unsigned SCREEN_H    = 160;
  localparam int          ITEM_TARGET = 850;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          DRAIN_TAIL  = 10;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         func;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] entry_color;
    logic [COORD_W-1:0] line_x;
    logic [COORD_W-1:0] line_y;
    logic [COORD_W-1:0] line_width;
    logic [2:0]         disposal;
    logic [INDEX_W-1:0] transparent_index;
    logic [INDEX_W-1:0] background_index;
    logic               has_transparency;
  } req_t;

  logic               clk               = 1'b0;
  logic               rst               = 1'b1;
  logic               req_valid         = 1'b0;
  logic               req_stall;
  logic [1:0]         func              = '0;
  logic [INDEX_W-1:0] index             = '0;
  logic [COLOR_W-1:0] entry_color       = '0;
  logic [COORD_W-1:0] line_x            = '0;
  logic [COORD_W-1:0] line_y            = '0;
  logic [COORD_W-1:0] line_width        = '0;
  logic [2:0]         disposal          = '0;
  logic [INDEX_W-1:0] transparent_index = '0;
  logic [INDEX_W-1:0] background_index  = '0;
  logic               has_transparency  = 1'b0;
  logic               pixel_valid;
  logic               pixel_stall       = 1'b0;
  logic [COL_W-1:0]   out_x;
  logic [ROW_W-1:0]   out_y;
  logic [COLOR_W-1:0] out_color;
  int                 fail_count;
  int                 pending;

  int                 items_sent = 0;
  int                 burst_left = 0;
  bit                 pal_known [PALETTE_DEPTH];
  logic [INDEX_W-1:0] known_list [$];
  int                 idle_cycles = 0;
  int                 stall_mode  = 0;
  int                 mode_left   = 0;
  logic [3:0]         stall_phase = '0;

  palette_line_compositor #(
    .SCREEN_COLS (SCREEN_W),
    .SCREEN_ROWS (SCREEN_H)
  ) u_top (.*);

  pcomp_checker #(
    .SCREEN_COLS (SCREEN_W),
    .SCREEN_ROWS (SCREEN_H)
  ) u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 1'b1;
    case (stall_mode)
      0:       pixel_stall <= 1'b0;
      1:       pixel_stall <= ($urandom_range(0, 99) < 30);
      2:       pixel_stall <= (stall_phase < 4'd11);
      default: pixel_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (pixel_valid && !pixel_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic req_t noise_req();
    req_t r;
    r.func              = FUNC_UNUSED;
    r.index             = INDEX_W'($urandom);
    r.entry_color       = COLOR_W'($urandom);
    r.line_x            = COORD_W'($urandom);
    r.line_y            = COORD_W'($urandom);
    r.line_width        = COORD_W'($urandom);
    r.disposal          = 3'($urandom);
    r.transparent_index = INDEX_W'($urandom);
    r.background_index  = INDEX_W'($urandom);
    r.has_transparency  = 1'($urandom);
    return r;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_known();
    return known_list[$urandom_range(0, known_list.size() - 1)];
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    req_valid         <= 1'b1;
    func              <= r.func;
    index             <= r.index;
    entry_color       <= r.entry_color;
    line_x            <= r.line_x;
    line_y            <= r.line_y;
    line_width        <= r.line_width;
    disposal          <= r.disposal;
    transparent_index <= r.transparent_index;
    background_index  <= r.background_index;
    has_transparency  <= r.has_transparency;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    if (r.func == FUNC_PALETTE && !pal_known[r.index]) begin
      pal_known[r.index] = 1'b1;
      known_list.push_back(r.index);
    end
  endtask

  task automatic send_palette(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
    req_t r;
    r             = noise_req();
    r.func        = FUNC_PALETTE;
    r.index       = idx;
    r.entry_color = color;
    send_req(r);
  endtask

  task automatic send_line(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] w, input logic [2:0] disp,
                           input logic [INDEX_W-1:0] ti, input logic [INDEX_W-1:0] bi,
                           input logic ht);
    req_t r;
    r                   = noise_req();
    r.func              = FUNC_LINE;
    r.line_x            = x;
    r.line_y            = y;
    r.line_width        = w;
    r.disposal          = disp;
    r.transparent_index = ti;
    r.background_index  = bi;
    r.has_transparency  = ht;
    send_req(r);
  endtask

  task automatic send_pixel(input logic [INDEX_W-1:0] idx);
    req_t r;
    r       = noise_req();
    r.func  = FUNC_PIXEL;
    r.index = idx;
    send_req(r);
  endtask

  task automatic send_unused();
    send_req(noise_req());
  endtask

  task automatic wait_drained();
    req_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [COORD_W-1:0] lx, ly, lw;
    logic [2:0]         disp;
    logic [INDEX_W-1:0] ti, bi;
    int                 span_len;
    int                 n;
    bit                 held_once;
    held_once = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_palette(8'h00, 16'h0000);
    send_palette(8'hFF, 16'hFFFF);
    send_palette(8'hAA, 16'h5555);
    send_palette(8'h55, 16'hAAAA);
    send_palette(8'h01, 16'h1234);
    send_pixel(8'h00);
    send_line(16'd0, 16'd0, 16'd0, 3'd0, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00);
    send_line(16'd127, 16'd159, 16'hFFFF, 3'd0, 8'hAA, 8'h00, 1'b1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h55);
    send_line(16'd128, 16'd0, 16'd4, 3'd0, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h01);
    send_line(16'd0, 16'd160, 16'd4, 3'd0, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h01);
    send_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF, 8'hFF, 1'b1);
    send_line(16'd10, 16'd5, 16'd4, DISPOSAL_RESTORE, 8'hAA, 8'h55, 1'b1);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    send_line(16'd0, 16'd1, 16'd3, 3'd7, 8'h01, 8'h00, 1'b1);
    send_pixel(8'h01);
    send_pixel(8'hFF);
    send_unused();
    send_pixel(8'h00);

    while (items_sent < ITEM_TARGET) begin
      if (!held_once && items_sent >= ITEM_TARGET / 2) begin
        wait_drained();
        held_once = 1'b1;
      end
      n = $urandom_range(0, 99);
      if (n < 12) begin
        send_palette(INDEX_W'($urandom), COLOR_W'($urandom));
      end else if (n < 15) begin
        send_unused();
      end else if (n < 18) begin
        send_pixel(pick_known());
      end else begin
        case ($urandom_range(0, 9))
          0:       lx = '0;
          1:       lx = COORD_W'(SCREEN_W - 1);
          2:       lx = COORD_W'(SCREEN_W);
          3:       lx = COORD_W'($urandom);
          default: lx = COORD_W'($urandom_range(0, SCREEN_W - 1));
        endcase
        case ($urandom_range(0, 9))
          0:       ly = '0;
          1:       ly = COORD_W'(SCREEN_H - 1);
          2:       ly = COORD_W'(SCREEN_H);
          3:       ly = COORD_W'($urandom);
          default: ly = COORD_W'($urandom_range(0, SCREEN_H - 1));
        endcase
        case ($urandom_range(0, 19))
          0:       lw = '0;
          1:       lw = COORD_W'($urandom);
          2:       lw = COORD_W'($urandom_range(20, 140));
          3:       lw = COORD_W'(SCREEN_W - lx);
          default: lw = COORD_W'($urandom_range(1, 10));
        endcase
        disp = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 4) begin
          disp = DISPOSAL_RESTORE;
        end
        ti = INDEX_W'($urandom);
        if ($urandom_range(0, 9) < 6) begin
          ti = pick_known();
        end
        bi = INDEX_W'($urandom);
        if (disp == DISPOSAL_RESTORE && pal_known[ti]) begin
          bi = pick_known();
        end
        send_line(lx, ly, lw, disp, ti, bi, 1'($urandom));
        if (ly >= SCREEN_H || lx >= SCREEN_W) begin
          span_len = 0;
        end else if (int'(lw) + int'(lx) > SCREEN_W) begin
          span_len = int'(SCREEN_W) - int'(lx);
        end else begin
          span_len = int'(lw);
        end
        n = span_len + int'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 15) begin
          n = int'($urandom_range(0, span_len));
        end
        repeat (n) begin
          if ($urandom_range(0, 99) < 8) begin
            send_palette(INDEX_W'($urandom), COLOR_W'($urandom));
          end
          if ($urandom_range(0, 99) < 35 && pal_known[ti]) begin
            send_pixel(ti);
          end else begin
            send_pixel(pick_known());
          end
        end
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
